// ===== rtl/core/ili_pkg.sv =====
// ----------------------------------------------------------------------------
// ili_pkg: shared types and constants for the indexed list
// Sizes, operation and status codes, and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package ili_pkg;

  localparam int CAPACITY  = 128;
  localparam int WORD_BITS = 64;

  // Fixed field widths of the channels
  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int VAL_W   = 64;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 8;

  localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W = $clog2(CAPACITY + 1);
  // Common width for index/length/position compares
  localparam int CMP_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef logic [WORD_BITS-1:0] word_t;

  // Command seen by every cell; en is set only for an accepted, legal beat
  typedef struct packed {
    logic             en;
    op_e              op;
    logic [CMP_W-1:0] index;
    word_t            value;
  } cmd_t;

endpackage

// ===== rtl/core/ili_in_if.sv =====
// ----------------------------------------------------------------------------
// ili_in_if: request channel of the indexed list
// Valid/ready handshake carrying one operation per beat.
// ----------------------------------------------------------------------------
interface ili_in_if;
  logic                        valid;
  logic                        ready;
  logic [ili_pkg::OP_W-1:0]    op;
  logic [ili_pkg::IDX_W-1:0]   index;
  logic [ili_pkg::VAL_W-1:0]   value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

// ===== rtl/core/ili_out_if.sv =====
// ----------------------------------------------------------------------------
// ili_out_if: result channel of the indexed list
// Valid/ready handshake carrying one result per beat.
// ----------------------------------------------------------------------------
interface ili_out_if;
  logic                          valid;
  logic                          ready;
  logic [ili_pkg::VAL_W-1:0]     read_value;
  logic [ili_pkg::STAT_W-1:0]    status;
  logic [ili_pkg::COUNT_W-1:0]   count;
  logic                          is_empty;

  modport source (output valid, output read_value, output status, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input count,
                  input is_empty, output ready);
endinterface

// ===== rtl/core/indexed_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: ordered word list with insert/delete by shifting
// A row of slot cells shifts all entries in parallel; one register holds length.
// ----------------------------------------------------------------------------
// The result is registered: its beat is valid in the cycle after the request beat is accepted.
// Throughput: one operation per cycle while the result side drains; every slot shifts in the same edge.
// The request side is ready whenever the result register is empty or drained.
// Reset clears the length and the result valid; slot contents stay unknown
// until written and are never read before that.
module indexed_list_insert_delete (
  input  logic       clk_i,
  input  logic       rst_ni,
  ili_in_if.sink     in_i,
  ili_out_if.source  out_o
);

  logic [ili_pkg::LEN_W-1:0]    len_q, len_d;
  logic [ili_pkg::CMP_W-1:0]    idx_ext, len_ext;
  logic                         accept;
  ili_pkg::status_e             status;
  ili_pkg::cmd_t                cmd;
  ili_pkg::word_t               words [ili_pkg::CAPACITY];
  ili_pkg::word_t               rds   [ili_pkg::CAPACITY];
  ili_pkg::word_t               rd_sel;
  ili_pkg::word_t               rd_d;

  logic                         out_valid_q;
  ili_pkg::word_t               rd_q;
  ili_pkg::status_e             status_q;
  logic [ili_pkg::LEN_W-1:0]    count_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign idx_ext = ili_pkg::CMP_W'(in_i.index);
  assign len_ext = ili_pkg::CMP_W'(len_q);

  always_comb begin
    status = ili_pkg::ST_OK;
    if (ili_pkg::op_e'(in_i.op) == ili_pkg::OP_INSERT) begin
      if (idx_ext > len_ext) status = ili_pkg::ST_RANGE;
      else if (len_ext == ili_pkg::CMP_W'(ili_pkg::CAPACITY)) status = ili_pkg::ST_FULL;
    end else if (idx_ext >= len_ext) begin
      status = ili_pkg::ST_RANGE;
    end
  end

  assign cmd.en    = accept && (status == ili_pkg::ST_OK);
  assign cmd.op    = ili_pkg::op_e'(in_i.op);
  assign cmd.index = idx_ext;
  assign cmd.value = ili_pkg::WORD_BITS'(in_i.value);

  for (genvar g = 0; g < ili_pkg::CAPACITY; g++) begin : g_cell
    ili_pkg::word_t left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end
    if (g == ili_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end
    ili_cell u_cell (
      .clk_i   (clk_i),
      .pos_i   (ili_pkg::POS_W'(g)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[g]),
      .rd_o    (rds[g])
    );
  end

  // AND-OR select: only the addressed cell drives a nonzero word
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < ili_pkg::CAPACITY; i++) begin
      rd_sel = rd_sel | rds[i];
    end
  end

  always_comb begin
    len_d = len_q;
    rd_d  = '0;
    if (cmd.en) begin
      unique case (cmd.op)
        ili_pkg::OP_READ:   rd_d = rd_sel;
        ili_pkg::OP_INSERT: len_d = len_q + ili_pkg::LEN_W'(1);
        ili_pkg::OP_DELETE: begin
          rd_d  = rd_sel;
          len_d = len_q - ili_pkg::LEN_W'(1);
        end
        default: rd_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      if (accept) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= rd_d;
      status_q <= status;
      count_q  <= len_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = ili_pkg::VAL_W'(rd_q);
  assign out_o.status     = status_q;
  assign out_o.count      = ili_pkg::COUNT_W'(count_q);
  assign out_o.is_empty   = (count_q == '0);

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ili_pkg::CMP_W'(len_q) <= ili_pkg::CMP_W'(ili_pkg::CAPACITY))
    else $error("list length exceeds capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.en && cmd.op == ili_pkg::OP_INSERT |=> len_q == $past(len_q) + ili_pkg::LEN_W'(1))
    else $error("insert did not grow the list");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status != ili_pkg::ST_OK |=> len_q == $past(len_q) && rd_q == '0)
    else $error("rejected beat changed the list or returned data");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> count_q == len_q)
    else $error("result count differs from list length");

endmodule

// ===== rtl/core/ili_cell.sv =====
// ----------------------------------------------------------------------------
// ili_cell: one list slot
// Holds one word; loads the new value, its left or right neighbor, or keeps.
// ----------------------------------------------------------------------------
module ili_cell (
  input  logic                        clk_i,
  input  logic [ili_pkg::POS_W-1:0]   pos_i,
  input  ili_pkg::cmd_t               cmd_i,
  input  ili_pkg::word_t              left_i,
  input  ili_pkg::word_t              right_i,
  output ili_pkg::word_t              word_o,
  output ili_pkg::word_t              rd_o
);

  ili_pkg::word_t                 word_q;
  ili_pkg::word_t                 word_d;
  logic [ili_pkg::CMP_W-1:0]      pos;
  logic                           hit;
  logic                           above;

  assign pos   = ili_pkg::CMP_W'(pos_i);
  assign hit   = (cmd_i.index == pos);
  assign above = (pos > cmd_i.index);

  always_comb begin
    word_d = word_q;
    if (cmd_i.en) begin
      unique case (cmd_i.op)
        ili_pkg::OP_WRITE: begin
          if (hit) word_d = cmd_i.value;
        end
        ili_pkg::OP_INSERT: begin
          if (hit) word_d = cmd_i.value;
          else if (above) word_d = left_i;
        end
        ili_pkg::OP_DELETE: begin
          // slots at and past the index pull from the right
          if (hit || above) word_d = right_i;
        end
        default: word_d = word_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign rd_o   = hit ? word_q : '0;

endmodule

// ===== dv/tb_indexed_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_delete: self-checking bench for the indexed list
// Drives read/overwrite/insert/delete requests with random gaps, tracks the
// list in a shadow copy and checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_delete;
  import ili_pkg::*;

  localparam int GAP_MAX      = 5;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 200;
  localparam int IDLE_LIMIT   = 4 * HOLD_CYCLES + 1000;
  localparam int RANDOM_ITEMS = 725;
  localparam int DRAIN_CYCLES = 3;
  localparam int BURST_SPAN   = 50;

  typedef struct {
    word_t                read_value;
    status_e              status;
    logic [COUNT_W-1:0]   count;
    logic                 is_empty;
  } list_result_t;

  // Shadow copy of the list plus the results still owed by the block
  class list_tracker;
    word_t        slots[CAPACITY];
    int           length;
    list_result_t owed_q[$];
    int unsigned  errors;

    function new();
      length = 0;
      errors = 0;
    endfunction

    function void apply_request(op_e op, logic [IDX_W-1:0] index, logic [VAL_W-1:0] value);
      list_result_t res;
      int           idx;
      int           j;
      word_t        word;
      idx  = int'(index);
      word = value[WORD_BITS-1:0];
      res.read_value = '0;
      res.status     = ST_OK;
      if (op == OP_INSERT) begin
        // range check wins over the full check
        if (idx > length) begin
          res.status = ST_RANGE;
        end else if (length >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (j = length; j > idx; j--) slots[j] = slots[j-1];
          slots[idx] = word;
          length++;
        end
      end else if (idx >= length) begin
        res.status = ST_RANGE;
      end else if (op == OP_READ) begin
        res.read_value = slots[idx];
      end else if (op == OP_WRITE) begin
        slots[idx] = word;
      end else begin
        res.read_value = slots[idx];
        for (j = idx; j + 1 < length; j++) slots[j] = slots[j+1];
        length--;
      end
      res.count    = COUNT_W'(length);
      res.is_empty = (length == 0);
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [VAL_W-1:0] read_value, logic [STAT_W-1:0] status,
                               logic [COUNT_W-1:0] count, logic is_empty);
      list_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result beat with nothing expected (read_value %h status %0d count %0d)",
                 $time, read_value, status, count);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (read_value !== VAL_W'(want.read_value)) begin
        $display("%0t: read_value expected %h actual %h", $time, want.read_value, read_value);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
      if (count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, count);
        errors++;
      end
      if (is_empty !== want.is_empty) begin
        $display("%0t: is_empty expected %b actual %b", $time, want.is_empty, is_empty);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ili_in_if  in_bus ();
  ili_out_if out_bus ();

  indexed_list_insert_delete DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  list_tracker tracker = new();

  bit growing        = 1'b1;
  bit sender_burst   = 1'b0;
  bit receiver_burst = 1'b0;
  int boundary_items = 0;
  int sent_items     = 0;
  int idle_cycles    = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic send_request(input op_e op, input logic [IDX_W-1:0] index,
                              input logic [VAL_W-1:0] value);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.op    <= op;
    in_bus.index <= index;
    in_bus.value <= value;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    tracker.apply_request(op, index, value);
    sent_items++;
    if (sent_items % BURST_SPAN == 0) sender_burst = !sender_burst;
  endtask

  // Grow toward full, then shrink toward empty, and repeat
  task automatic random_request();
    int               pick;
    int               len;
    op_e              op;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    len  = tracker.length;
    pick = $urandom_range(0, 99);
    if (pick < 70)      op = growing ? OP_INSERT : OP_DELETE;
    else if (pick < 78) op = growing ? OP_DELETE : OP_INSERT;
    else if (pick < 89) op = OP_READ;
    else                op = OP_WRITE;
    if ($urandom_range(0, 99) < 12)  index = IDX_W'($urandom_range(0, 255));
    else if (op == OP_INSERT)        index = IDX_W'($urandom_range(0, len));
    else if (len > 0)                index = IDX_W'($urandom_range(0, len - 1));
    else                             index = '0;
    case ($urandom_range(0, 9))
      0:       value = '0;
      1:       value = '1;
      default: value = {$urandom, $urandom};
    endcase
    send_request(op, index, value);
    if ((growing && len == CAPACITY) || (!growing && len == 0)) boundary_items++;
    if (boundary_items >= 4) begin
      growing        = !growing;
      boundary_items = 0;
    end
  endtask

  initial begin : stimulus
    rst_ni       = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.op    = OP_READ;
    in_bus.index = '0;
    in_bus.value = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: everything is out of range
    send_request(OP_READ,   8'd0,   '0);
    send_request(OP_WRITE,  8'd0,   '1);
    send_request(OP_DELETE, 8'd0,   '0);
    send_request(OP_INSERT, 8'd1,   '1);
    send_request(OP_INSERT, 8'd255, '1);
    // append, front and middle inserts
    send_request(OP_INSERT, 8'd0,   '1);
    send_request(OP_INSERT, 8'd1,   '0);
    send_request(OP_INSERT, 8'd0,   64'hA5A5_A5A5_A5A5_A5A5);
    send_request(OP_INSERT, 8'd1,   64'h0123_4567_89AB_CDEF);
    send_request(OP_READ,   8'd0,   '0);
    send_request(OP_READ,   8'd1,   '0);
    send_request(OP_READ,   8'd2,   '0);
    send_request(OP_READ,   8'd3,   '0);
    send_request(OP_READ,   8'd4,   '0);
    send_request(OP_READ,   8'd255, '0);
    send_request(OP_WRITE,  8'd3,   64'h5555_5555_5555_5555);
    send_request(OP_READ,   8'd3,   '0);
    send_request(OP_WRITE,  8'd4,   '1);
    send_request(OP_DELETE, 8'd4,   '0);
    send_request(OP_INSERT, 8'd5,   '1);
    // middle, last, then down to empty
    send_request(OP_DELETE, 8'd1,   '0);
    send_request(OP_DELETE, 8'd2,   '0);
    send_request(OP_DELETE, 8'd0,   '0);
    send_request(OP_DELETE, 8'd0,   '0);
    send_request(OP_DELETE, 8'd0,   '0);

    repeat (RANDOM_ITEMS) random_request();
    in_bus.valid <= 1'b0;

    while (tracker.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    int beats;
    beats         = 0;
    out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // one long hold-off so the output register fills and input stalls
      if (beats == HOLD_AFTER) stall = HOLD_CYCLES;
      else if (receiver_burst) stall = 0;
      else stall = $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
      tracker.check_result(out_bus.read_value, out_bus.status, out_bus.count,
                           out_bus.is_empty);
      beats++;
      if (beats % BURST_SPAN == 0) receiver_burst = !receiver_burst;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
